// ----- rtl/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants for sliding window max/min
// Beat types for both channels, the sweep record passed between cells.
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int DATA_W         = 32;
	localparam int WLEN_W         = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

	localparam logic signed [DATA_W-1:0] DATA_MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] DATA_MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     first_sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] window_max;
		logic signed [DATA_W-1:0] window_min;
	} out_beat_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo;
	} sweep_t;

endpackage

// ----- rtl/swmm_cell.sv -----
// ----------------------------------------------------------------------------
// swmm_cell: one history cell of the sliding window chain
// Holds one sample, shifts it on to the next cell on a new beat, and folds
// it into the max/min sweep that passes through one cell per cycle.
// ----------------------------------------------------------------------------
module swmm_cell #(
	parameter int IDX   = 0,
	parameter int CMP_W = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift_en,
	input  logic signed [swmm_pkg::DATA_W-1:0]  shift_in,
	output logic signed [swmm_pkg::DATA_W-1:0]  shift_out,
	input  logic [CMP_W-1:0]                    eff_len,
	input  swmm_pkg::sweep_t                    sweep_in,
	output swmm_pkg::sweep_t                    sweep_out
);

	logic signed [swmm_pkg::DATA_W-1:0] sample_q;
	logic signed [swmm_pkg::DATA_W-1:0] hi_q;
	logic signed [swmm_pkg::DATA_W-1:0] lo_q;
	logic                               valid_q;
	logic                               in_window;

	assign in_window = (CMP_W'(IDX) < eff_len);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= shift_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= sweep_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_in.valid) begin
			hi_q <= (in_window && (sample_q > sweep_in.hi)) ? sample_q : sweep_in.hi;
			lo_q <= (in_window && (sample_q < sweep_in.lo)) ? sample_q : sweep_in.lo;
		end
	end

	assign shift_out = sample_q;
	assign sweep_out = '{valid: valid_q, hi: hi_q, lo: lo_q};

endmodule

// ----- rtl/sliding_window_max_min.sv -----
// Result path: an accepted beat sets the go register, then its sweep walks
// the WINDOW_MAX cells and lands in the output register. Throughput: one
// beat per cycle while the sequence is shorter than the window; once results
// are due, no new beat is taken until the max/min sweep has walked the cell
// chain one cell per cycle; no beat is taken while a result beat is stalled.
// Reset: fill count cleared, window_len = 1, no result pending; cell
// samples are undefined until shifted in.
// ----------------------------------------------------------------------------
// sliding_window_max_min: max and min over the last window_len samples
// A shift chain of WINDOW_MAX cells holds the history; a sweep record runs
// down the chain and collects max/min over the cells inside the window.
// ----------------------------------------------------------------------------
module sliding_window_max_min #(
	parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  swmm_pkg::in_beat_t            in_beat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output swmm_pkg::out_beat_t           out_beat,
	input  logic                          cfg_we,
	input  logic [swmm_pkg::WLEN_W-1:0]   cfg_wdata
);

	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (FILL_W > swmm_pkg::WLEN_W) ? FILL_W : swmm_pkg::WLEN_W;

	logic [swmm_pkg::WLEN_W-1:0]          window_len_q;
	logic [FILL_W-1:0]                    fill_q;
	logic [FILL_W-1:0]                    fill_next;
	logic [CMP_W-1:0]                     wlen_ext;
	logic [CMP_W-1:0]                     eff_len;
	logic                                 accept;
	logic                                 due;
	logic                                 go_q;
	logic                                 sweeping_q;
	logic                                 out_valid_q;
	swmm_pkg::out_beat_t                  out_q;

	logic signed [swmm_pkg::DATA_W-1:0]   chain [WINDOW_MAX+1];
	swmm_pkg::sweep_t                     sweep [WINDOW_MAX+1];

	assign wlen_ext = CMP_W'(window_len_q);

	always_comb begin
		if (wlen_ext == '0) begin
			eff_len = CMP_W'(1);
		end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
			eff_len = CMP_W'(WINDOW_MAX);
		end else begin
			eff_len = wlen_ext;
		end
	end

	assign in_stall = sweeping_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (in_beat.first_sample) begin
			fill_next = FILL_W'(1);
		end else if (fill_q < FILL_W'(WINDOW_MAX)) begin
			fill_next = fill_q + FILL_W'(1);
		end else begin
			fill_next = fill_q;
		end
	end

	assign due = (CMP_W'(fill_next) >= eff_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swmm_pkg::WLEN_RESET;
		end else if (cfg_we) begin
			window_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			go_q       <= 1'b0;
			sweeping_q <= 1'b0;
		end else begin
			go_q <= accept && due;
			if (accept) begin
				fill_q <= fill_next;
			end
			if (accept && due) begin
				sweeping_q <= 1'b1;
			end else if (sweep[WINDOW_MAX].valid) begin
				sweeping_q <= 1'b0;
			end
		end
	end

	assign chain[0] = in_beat.sample;
	assign sweep[0] = '{valid: go_q, hi: swmm_pkg::DATA_MOST_NEG, lo: swmm_pkg::DATA_MOST_POS};

	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		swmm_cell #(
			.IDX   (k),
			.CMP_W (CMP_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept),
			.shift_in  (chain[k]),
			.shift_out (chain[k+1]),
			.eff_len   (eff_len),
			.sweep_in  (sweep[k]),
			.sweep_out (sweep[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sweep[WINDOW_MAX].valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep[WINDOW_MAX].valid) begin
			out_q.window_max <= sweep[WINDOW_MAX].hi;
			out_q.window_min <= sweep[WINDOW_MAX].lo;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

`ifndef ASSERT_OFF
	a_tail_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep[WINDOW_MAX].valid |-> sweeping_q)
		else $error("sweep tail without active sweep");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		sweep[WINDOW_MAX].valid |-> !out_valid_q)
		else $error("sweep result would overwrite pending beat");

	a_go_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> !go_q)
		else $error("sweep launched twice");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_MAX))
		else $error("fill count past window depth");

	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping_q |-> !accept)
		else $error("beat accepted during sweep");
`endif

endmodule
